[rtl/ppm_frame_symbol_encoder_unit_assert.svh]
// Assertion macros for the PPM frame symbol encoder; used by the symbol generator.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PPM_FRAME_SYMBOL_ENCODER_UNIT_ASSERT_SVH
`define PPM_FRAME_SYMBOL_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PPM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppm: implication check failed");

// Next-cycle implication, disabled during reset.
`define PPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppm: next-cycle check failed");

`endif

[rtl/ppm_pkg.sv]
// Shared types, constants and helper functions of the PPM frame symbol encoder.
// Depends on nothing; used by every module of the block.
package ppm_pkg;

  localparam int CH_US_W          = 12;
  localparam int TICK_W           = 18;
  localparam int CHUNK_W          = 15;
  localparam int APB_ADDR_W       = 4;
  localparam int APB_DATA_W       = 32;
  localparam int TICKS_PER_US_DEF = 10;
  localparam int FIFO_DEPTH_DEF   = 2;

  localparam logic [CHUNK_W-1:0] CHUNK_MAX  = 15'h7FFF;
  localparam logic [TICK_W-1:0]  FRAME_RST  = 18'd200000;
  localparam logic [TICK_W-1:0]  GAP_RST    = 18'd30000;
  localparam logic [CHUNK_W-1:0] PULSE_RST  = 15'd3000;
  localparam logic               ACTIVE_RST = 1'b1;

  typedef enum logic [1:0] {
    REG_FRAME  = 2'd0,
    REG_GAP    = 2'd1,
    REG_PULSE  = 2'd2,
    REG_ACTIVE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TICK_W-1:0]  frame_ticks;
    logic [TICK_W-1:0]  gap_ticks;
    logic [CHUNK_W-1:0] pulse_ticks;
    logic               active_high;
  } cfg_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] ch_ticks;
    logic               last;
    logic [TICK_W-1:0]  rem;
  } cmd_t;

  function automatic logic [CHUNK_W-1:0] min_chunk(input logic [TICK_W-1:0] v);
    logic [CHUNK_W-1:0] r;
    if (v > TICK_W'(CHUNK_MAX)) begin
      r = CHUNK_MAX;
    end else begin
      r = v[CHUNK_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [TICK_W-1:0] sat_sub_tick(input logic [TICK_W-1:0] a,
                                                     input logic [TICK_W-1:0] b);
    logic [TICK_W-1:0] r;
    if (a > b) begin
      r = a - b;
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

[rtl/ppm_frame_symbol_encoder_unit.sv]
// Top level of the PPM frame symbol encoder: configuration registers on an APB-style
// port, front end, command queue and symbol generator. Depends on ppm_pkg.
//
// Channel requests (channel_us, last_channel) enter on chan_valid/chan_ready. Each
// request yields one symbol on sym_valid/sym_ready: a marker pulse at the active level
// followed by the idle level for the rest of the channel period. A request marked as
// the last channel also yields a stop pulse and idle padding symbols, up to six
// symbols in total, and frame_end flags the final one.
// The front end takes one request at a time through scale, subtract and push steps,
// plus a gap step for the last channel; the push waits while the queue is full. The
// generator emits one symbol per cycle while sym_ready allows. chan_ready is high
// only while the front end is idle, so a stalled receiver fills the output register
// and the queue, and the front end then waits in its push step. Reset restores the
// register defaults, loads the frame time left with the frame length and empties the
// queue and output register. Writing the frame length also reloads the frame time
// left. The user must only write registers while the block is idle (not enforced).
module ppm_frame_symbol_encoder_unit #(
  parameter int TICKS_PER_US = ppm_pkg::TICKS_PER_US_DEF,
  parameter int FIFO_DEPTH   = ppm_pkg::FIFO_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ppm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ppm_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           chan_valid,
  output logic                           chan_ready,
  input  logic [ppm_pkg::CH_US_W-1:0]    channel_us,
  input  logic                           last_channel,
  output logic                           sym_valid,
  input  logic                           sym_ready,
  output logic                           first_level,
  output logic [ppm_pkg::CHUNK_W-1:0]    first_ticks,
  output logic                           second_level,
  output logic [ppm_pkg::CHUNK_W-1:0]    second_ticks,
  output logic                           run_last,
  output logic                           frame_end
);
  import ppm_pkg::*;

  cfg_t     cfg;
  logic     wr_en;
  reg_idx_t reg_idx;
  logic     frame_wr;
  logic     push;
  cmd_t     push_data;
  logic     fifo_full;
  logic     fifo_empty;
  logic     pop;
  cmd_t     pop_data;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign reg_idx  = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign frame_wr = wr_en && (reg_idx == REG_FRAME);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_ticks <= FRAME_RST;
      cfg.gap_ticks   <= GAP_RST;
      cfg.pulse_ticks <= PULSE_RST;
      cfg.active_high <= ACTIVE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME:  cfg.frame_ticks <= pwdata[TICK_W-1:0];
        REG_GAP:    cfg.gap_ticks   <= pwdata[TICK_W-1:0];
        REG_PULSE:  cfg.pulse_ticks <= pwdata[CHUNK_W-1:0];
        REG_ACTIVE: cfg.active_high <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME:  prdata = APB_DATA_W'(cfg.frame_ticks);
      REG_GAP:    prdata = APB_DATA_W'(cfg.gap_ticks);
      REG_PULSE:  prdata = APB_DATA_W'(cfg.pulse_ticks);
      REG_ACTIVE: prdata = APB_DATA_W'(cfg.active_high);
    endcase
  end

  ppm_front #(
    .TICKS_PER_US(TICKS_PER_US)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .frame_wr    (frame_wr),
    .frame_wdata (pwdata[TICK_W-1:0]),
    .chan_valid  (chan_valid),
    .chan_ready  (chan_ready),
    .channel_us  (channel_us),
    .last_channel(last_channel),
    .push        (push),
    .push_data   (push_data),
    .fifo_full   (fifo_full)
  );

  ppm_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (fifo_full),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (fifo_empty)
  );

  ppm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .fifo_empty  (fifo_empty),
    .pop         (pop),
    .cmd         (pop_data),
    .sym_valid   (sym_valid),
    .sym_ready   (sym_ready),
    .first_level (first_level),
    .first_ticks (first_ticks),
    .second_level(second_level),
    .second_ticks(second_ticks),
    .run_last    (run_last),
    .frame_end   (frame_end)
  );

endmodule

[rtl/ppm_front.sv]
// Front end: accepts channel requests, scales them to ticks, tracks the frame time left
// and queues one command per channel. Depends on ppm_pkg.
module ppm_front #(
  parameter int TICKS_PER_US = ppm_pkg::TICKS_PER_US_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ppm_pkg::cfg_t                 cfg,
  input  logic                          frame_wr,
  input  logic [ppm_pkg::TICK_W-1:0]    frame_wdata,
  input  logic                          chan_valid,
  output logic                          chan_ready,
  input  logic [ppm_pkg::CH_US_W-1:0]   channel_us,
  input  logic                          last_channel,
  output logic                          push,
  output ppm_pkg::cmd_t                 push_data,
  input  logic                          fifo_full
);
  import ppm_pkg::*;

  localparam int TpuW = $clog2(TICKS_PER_US + 1);
  localparam int DurW = CH_US_W + TpuW;
  localparam int CmpW = (DurW > TICK_W) ? DurW : TICK_W;
  localparam logic [TpuW-1:0] Tpu = TpuW'(TICKS_PER_US);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_SUB  = 5'b00100,
    F_REM  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t            state;
  logic [CH_US_W-1:0] us;
  logic               last;
  logic [DurW-1:0]    dur;
  logic [TICK_W-1:0]  ticks_left;
  logic [CHUNK_W-1:0] ch_ticks;
  logic [TICK_W-1:0]  rem;

  logic [CmpW-1:0]    dur_x;
  logic [CmpW-1:0]    tl_x;
  logic [CmpW-1:0]    pulse_x;
  logic [CmpW-1:0]    ch_diff;
  logic [TICK_W-1:0]  tl_sub;
  logic [CHUNK_W-1:0] ch_sat;
  logic [TICK_W-1:0]  rem_sub;
  logic [TICK_W-1:0]  rem_val;

  always_comb begin
    dur_x   = CmpW'(dur);
    tl_x    = CmpW'(ticks_left);
    pulse_x = CmpW'(cfg.pulse_ticks);
    tl_sub  = (tl_x > dur_x) ? TICK_W'(tl_x - dur_x) : '0;
    ch_diff = (dur_x > pulse_x) ? (dur_x - pulse_x) : '0;
    ch_sat  = (ch_diff > CmpW'(CHUNK_MAX)) ? CHUNK_MAX : ch_diff[CHUNK_W-1:0];
    rem_sub = sat_sub_tick(ticks_left, TICK_W'(cfg.pulse_ticks));
    rem_val = (rem_sub < cfg.gap_ticks) ? cfg.gap_ticks : rem_sub;
  end

  assign chan_ready = (state == F_IDLE);
  assign push       = (state == F_PUSH) && !fifo_full;
  assign push_data  = '{ch_ticks: ch_ticks, last: last, rem: rem};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      ticks_left <= FRAME_RST;
    end else begin
      if (frame_wr) begin
        ticks_left <= frame_wdata;
      end
      unique case (state)
        F_IDLE: begin
          if (chan_valid) begin
            state <= F_MUL;
          end
        end
        F_MUL: begin
          state <= F_SUB;
        end
        F_SUB: begin
          ticks_left <= tl_sub;
          state      <= last ? F_REM : F_PUSH;
        end
        F_REM: begin
          ticks_left <= cfg.frame_ticks;
          state      <= F_PUSH;
        end
        F_PUSH: begin
          if (!fifo_full) begin
            state <= F_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (chan_valid && chan_ready) begin
      us   <= channel_us;
      last <= last_channel;
    end
    if (state == F_MUL) begin
      dur <= DurW'(us) * DurW'(Tpu);
    end
    if (state == F_SUB) begin
      ch_ticks <= ch_sat;
      rem      <= '0;
    end
    if (state == F_REM) begin
      rem <= rem_val;
    end
  end

endmodule

[rtl/ppm_fifo.sv]
// Short command queue between the front end and the symbol generator.
// Depends on ppm_pkg for the command type.
module ppm_fifo #(
  parameter int DEPTH = ppm_pkg::FIFO_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ppm_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output ppm_pkg::cmd_t pop_data,
  output logic          empty
);
  import ppm_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);

  cmd_t            entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/ppm_back.sv]
// Symbol generator: turns queued commands into channel, stop and padding symbols
// held in an output register. Depends on ppm_pkg and the assertion macro header.
`include "ppm_frame_symbol_encoder_unit_assert.svh"

module ppm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  ppm_pkg::cfg_t               cfg,
  input  logic                        fifo_empty,
  output logic                        pop,
  input  ppm_pkg::cmd_t               cmd,
  output logic                        sym_valid,
  input  logic                        sym_ready,
  output logic                        first_level,
  output logic [ppm_pkg::CHUNK_W-1:0] first_ticks,
  output logic                        second_level,
  output logic [ppm_pkg::CHUNK_W-1:0] second_ticks,
  output logic                        run_last,
  output logic                        frame_end
);
  import ppm_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_STOP = 3'b010,
    B_PAD  = 3'b100
  } bstate_t;

  bstate_t            state;
  logic [TICK_W-1:0]  rem;

  logic               act;
  logic               idle;
  logic               load;
  logic               emit;
  logic [CHUNK_W-1:0] d0;
  logic [TICK_W-1:0]  r1;
  logic [CHUNK_W-1:0] d1;
  logic [TICK_W-1:0]  r2;

  always_comb begin
    act  = cfg.active_high;
    idle = ~cfg.active_high;
    load = !sym_valid || sym_ready;
    pop  = (state == B_IDLE) && !fifo_empty && load;
    emit = load && (pop || (state == B_STOP) || (state == B_PAD));
    d0   = min_chunk(rem);
    r1   = rem - TICK_W'(d0);
    d1   = min_chunk(r1);
    r2   = r1 - TICK_W'(d1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      sym_valid <= 1'b0;
    end else begin
      if (load) begin
        sym_valid <= emit;
      end
      unique case (state)
        B_IDLE: begin
          if (pop && cmd.last) begin
            state <= B_STOP;
          end
        end
        B_STOP: begin
          if (load) begin
            state <= (r1 == '0) ? B_IDLE : B_PAD;
          end
        end
        B_PAD: begin
          if (load) begin
            state <= (r2 == '0) ? B_IDLE : B_PAD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rem <= cmd.rem;
    end else if (load && (state == B_STOP)) begin
      rem <= r1;
    end else if (load && (state == B_PAD)) begin
      rem <= r2;
    end
    if (emit) begin
      unique case (state)
        B_IDLE: begin
          first_level  <= act;
          first_ticks  <= cfg.pulse_ticks;
          second_level <= idle;
          second_ticks <= cmd.ch_ticks;
          run_last     <= !cmd.last;
          frame_end    <= 1'b0;
        end
        B_STOP: begin
          first_level  <= act;
          first_ticks  <= cfg.pulse_ticks;
          second_level <= idle;
          second_ticks <= d0;
          run_last     <= (r1 == '0);
          frame_end    <= (r1 == '0);
        end
        B_PAD: begin
          first_level  <= idle;
          first_ticks  <= d0;
          second_level <= idle;
          second_ticks <= d1;
          run_last     <= (r2 == '0);
          frame_end    <= (r2 == '0);
        end
      endcase
    end
  end

  `PPM_ASSERT_IMPLY(a_frame_end_run_last, clk, rst, sym_valid && frame_end, run_last)
  `PPM_ASSERT_IMPLY(a_no_pop_busy, clk, rst, state != B_IDLE, !pop)
  `PPM_ASSERT_IMPLY(a_pad_rem_nonzero, clk, rst, state == B_PAD, rem != '0)
  `PPM_ASSERT_NEXT(a_plain_channel_idle, clk, rst, pop && !cmd.last, state == B_IDLE)

endmodule

[verif/testbench.sv]
// Testbench for ppm_frame_symbol_encoder_unit: directed channel table, then random frames.
// Predicts symbols from its own copy of the frame state; depends on ppm_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int TICKS_PER_US = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_PHASES  = 7;
  localparam int PHASE_ITEMS  = 45;

  typedef struct packed {
    logic        first_level;
    logic [14:0] first_ticks;
    logic        second_level;
    logic [14:0] second_ticks;
    logic        run_last;
    logic        frame_end;
  } sym_t;

  typedef struct packed {
    logic known;
    sym_t sym;
  } first_sym_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    ppm_pkg::reg_idx_t idx;
    logic [31:0]       value;
    logic [11:0]       us;
    logic              last;
    logic              known;
    sym_t              sym;
  } row_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [ppm_pkg::APB_ADDR_W-1:0] paddr;
  logic [ppm_pkg::APB_DATA_W-1:0] pwdata;
  logic [ppm_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           chan_valid;
  logic                           chan_ready;
  logic [ppm_pkg::CH_US_W-1:0]    channel_us;
  logic                           last_channel;
  logic                           sym_valid;
  logic                           sym_ready = 1'b0;
  logic                           first_level;
  logic [ppm_pkg::CHUNK_W-1:0]    first_ticks;
  logic                           second_level;
  logic [ppm_pkg::CHUNK_W-1:0]    second_ticks;
  logic                           run_last;
  logic                           frame_end;

  logic [17:0] frame_len    = 18'd200000;
  logic [17:0] gap_len      = 18'd30000;
  logic [14:0] pulse_len    = 15'd3000;
  logic        active_level = 1'b1;
  logic [23:0] ticks_left   = 24'd200000;

  sym_t       expected_syms[$];
  first_sym_t typed_firsts[$];
  row_t       plan[$];
  int         mismatches  = 0;
  int         cycle_count = 0;
  int         burst_left  = 0;
  int         hold_token  = 0;
  int         hold_seen   = 0;
  int         hold_left   = 0;
  int         pattern_left = 0;
  int         pattern_mode = 0;

  ppm_frame_symbol_encoder_unit #(
    .TICKS_PER_US(TICKS_PER_US)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .chan_valid(chan_valid),
    .chan_ready(chan_ready),
    .channel_us(channel_us),
    .last_channel(last_channel),
    .sym_valid(sym_valid),
    .sym_ready(sym_ready),
    .first_level(first_level),
    .first_ticks(first_ticks),
    .second_level(second_level),
    .second_ticks(second_ticks),
    .run_last(run_last),
    .frame_end(frame_end)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [14:0] clip_chunk(input logic [23:0] v);
    return (v > 24'd32767) ? 15'h7FFF : v[14:0];
  endfunction

  function automatic logic [23:0] floor_sub(input logic [23:0] a, input logic [23:0] b);
    return (a > b) ? a - b : 24'd0;
  endfunction

  function automatic void encode_channel(input logic [11:0] us, input logic last);
    logic [23:0] dur;
    logic [23:0] rem;
    logic [14:0] c0;
    logic [14:0] c1;
    logic        idle;
    int          n;
    idle = ~active_level;
    dur = 24'(us) * 24'(TICKS_PER_US);
    ticks_left = floor_sub(ticks_left, dur);
    expected_syms.push_back('{active_level, pulse_len, idle,
                              clip_chunk(floor_sub(dur, 24'(pulse_len))), ~last, 1'b0});
    if (last) begin
      rem = floor_sub(ticks_left, 24'(pulse_len));
      if (rem < 24'(gap_len)) begin
        rem = 24'(gap_len);
      end
      c1 = clip_chunk(rem);
      rem = rem - 24'(c1);
      expected_syms.push_back('{active_level, pulse_len, idle, c1, rem == 0, rem == 0});
      n = 2;
      while (rem != 0 && n < 6) begin
        c0 = clip_chunk(rem);
        rem = rem - 24'(c0);
        c1 = clip_chunk(rem);
        rem = rem - 24'(c1);
        expected_syms.push_back('{idle, c0, idle, c1, rem == 0, rem == 0});
        n++;
      end
      ticks_left = 24'(frame_len);
    end
  endfunction

  function automatic void apply_write(input logic [3:0] addr, input logic [31:0] value);
    ppm_pkg::reg_idx_t idx;
    idx = ppm_pkg::reg_idx_t'(addr[3:2]);
    case (idx)
      ppm_pkg::REG_FRAME: begin
        frame_len = value[17:0];
        ticks_left = 24'(value[17:0]);
      end
      ppm_pkg::REG_GAP: begin
        gap_len = value[17:0];
      end
      ppm_pkg::REG_PULSE: begin
        pulse_len = value[14:0];
      end
      default: begin
        active_level = value[0];
      end
    endcase
  endfunction

  function automatic int pick_value(input int max_v, input int typ_lo, input int typ_hi);
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      return 0;
    end else if (sel == 1) begin
      return max_v;
    end else if (sel < 4) begin
      return $urandom_range(0, max_v);
    end
    return $urandom_range(typ_lo, typ_hi);
  endfunction

  // Prediction, register shadowing and symbol checking all happen in one process.
  always @(posedge clk) begin
    first_sym_t typed;
    sym_t       got;
    sym_t       want;
    int         slot;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        apply_write(paddr, pwdata);
      end
      if (chan_valid && chan_ready) begin
        slot = expected_syms.size();
        encode_channel(channel_us, last_channel);
        if (typed_firsts.size() > 0) begin
          typed = typed_firsts.pop_front();
          if (typed.known) begin
            expected_syms[slot] = typed.sym;
          end
        end
      end
      if (sym_valid && sym_ready) begin
        got = '{first_level, first_ticks, second_level, second_ticks, run_last, frame_end};
        if (expected_syms.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("cycle %0d: symbol with nothing expected: %0d/%0d %0d/%0d last %0d end %0d",
                     cycle_count, got.first_level, got.first_ticks, got.second_level,
                     got.second_ticks, got.run_last, got.frame_end);
          end
        end else begin
          want = expected_syms.pop_front();
          if (got.first_level !== want.first_level || got.first_ticks !== want.first_ticks ||
              got.second_level !== want.second_level ||
              got.second_ticks !== want.second_ticks ||
              got.run_last !== want.run_last || got.frame_end !== want.frame_end) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("cycle %0d: expected %0d/%0d %0d/%0d last %0d end %0d",
                       cycle_count, want.first_level, want.first_ticks, want.second_level,
                       want.second_ticks, want.run_last, want.frame_end);
              $display("cycle %0d: got      %0d/%0d %0d/%0d last %0d end %0d",
                       cycle_count, got.first_level, got.first_ticks, got.second_level,
                       got.second_ticks, got.run_last, got.frame_end);
            end
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      sym_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_mode = $urandom_range(0, 3);
        pattern_left = $urandom_range(1, 40);
      end
      pattern_left--;
      case (pattern_mode)
        0: sym_ready <= 1'b1;
        1: sym_ready <= ($urandom_range(0, 3) != 0);
        2: sym_ready <= ($urandom_range(0, 3) == 0);
        default: sym_ready <= (pattern_left > 8);
      endcase
    end
  end

  task automatic offer_channel(input logic [11:0] us, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        @(negedge clk);
        chan_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    chan_valid <= 1'b1;
    channel_us <= us;
    last_channel <= last;
    do @(posedge clk); while (!(chan_valid && chan_ready));
  endtask

  task automatic park_and_drain();
    @(negedge clk);
    chan_valid <= 1'b0;
    while (expected_syms.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input ppm_pkg::reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int   frame_size;
    int   sent;
    logic [11:0] us;
    logic [31:0] f_val;
    logic [31:0] g_val;
    logic [31:0] p_val;
    logic [31:0] a_val;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    chan_valid = 1'b0;
    channel_us = '0;
    last_channel = 1'b0;

    plan.push_back('{ROW_ITEM, ppm_pkg::REG_FRAME, 0, 12'd0, 1'b0, 1'b1,
                     '{1'b1, 15'd3000, 1'b0, 15'd0, 1'b1, 1'b0}});
    plan.push_back('{ROW_ITEM, ppm_pkg::REG_FRAME, 0, 12'd4095, 1'b0, 1'b1,
                     '{1'b1, 15'd3000, 1'b0, 15'd32767, 1'b1, 1'b0}});
    plan.push_back('{ROW_ITEM, ppm_pkg::REG_FRAME, 0, 12'd300, 1'b0, 1'b1,
                     '{1'b1, 15'd3000, 1'b0, 15'd0, 1'b1, 1'b0}});
    plan.push_back('{ROW_ITEM, ppm_pkg::REG_FRAME, 0, 12'd301, 1'b0, 1'b1,
                     '{1'b1, 15'd3000, 1'b0, 15'd10, 1'b1, 1'b0}});
    plan.push_back('{ROW_ITEM, ppm_pkg::REG_FRAME, 0, 12'd150, 1'b1, 1'b0, '0});
    repeat (5) begin
      plan.push_back('{ROW_ITEM, ppm_pkg::REG_FRAME, 0, 12'd4095, 1'b0, 1'b0, '0});
    end
    plan.push_back('{ROW_ITEM, ppm_pkg::REG_FRAME, 0, 12'd2048, 1'b1, 1'b0, '0});
    plan.push_back('{ROW_WRITE, ppm_pkg::REG_PULSE, 0, 12'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, ppm_pkg::REG_GAP, 0, 12'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, ppm_pkg::REG_FRAME, 0, 12'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, ppm_pkg::REG_ACTIVE, 0, 12'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, ppm_pkg::REG_FRAME, 0, 12'd0, 1'b1, 1'b1,
                     '{1'b0, 15'd0, 1'b1, 15'd0, 1'b0, 1'b0}});
    plan.push_back('{ROW_ITEM, ppm_pkg::REG_FRAME, 0, 12'd4095, 1'b1, 1'b1,
                     '{1'b0, 15'd0, 1'b1, 15'd32767, 1'b0, 1'b0}});
    plan.push_back('{ROW_WRITE, ppm_pkg::REG_PULSE, 32767, 12'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, ppm_pkg::REG_GAP, 262143, 12'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, ppm_pkg::REG_FRAME, 262143, 12'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, ppm_pkg::REG_ACTIVE, 1, 12'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, ppm_pkg::REG_FRAME, 0, 12'd0, 1'b0, 1'b1,
                     '{1'b1, 15'd32767, 1'b0, 15'd0, 1'b1, 1'b0}});
    plan.push_back('{ROW_ITEM, ppm_pkg::REG_FRAME, 0, 12'd0, 1'b1, 1'b0, '0});
    plan.push_back('{ROW_WRITE, ppm_pkg::REG_FRAME, 0, 12'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, ppm_pkg::REG_GAP, 40000, 12'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, ppm_pkg::REG_FRAME, 0, 12'd1, 1'b1, 1'b0, '0});
    plan.push_back('{ROW_WRITE, ppm_pkg::REG_FRAME, 100000, 12'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, ppm_pkg::REG_PULSE, 1000, 12'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, ppm_pkg::REG_FRAME, 0, 12'd2000, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, ppm_pkg::REG_FRAME, 50000, 12'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, ppm_pkg::REG_FRAME, 0, 12'd1000, 1'b1, 1'b0, '0});
    plan.push_back('{ROW_WRITE, ppm_pkg::REG_FRAME, 200000, 12'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, ppm_pkg::REG_GAP, 30000, 12'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, ppm_pkg::REG_PULSE, 3000, 12'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, ppm_pkg::REG_FRAME, 0, 12'd2730, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, ppm_pkg::REG_FRAME, 0, 12'd1365, 1'b1, 1'b0, '0});

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        park_and_drain();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        typed_firsts.push_back('{plan[i].known, plan[i].sym});
        offer_channel(plan[i].us, plan[i].last);
      end
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase > 0) begin
        park_and_drain();
        case (phase)
          1: begin
            f_val = 262143;
            g_val = 262143;
            p_val = 32767;
            a_val = 1;
          end
          2: begin
            f_val = 0;
            g_val = 0;
            p_val = 0;
            a_val = 0;
          end
          default: begin
            f_val = pick_value(262143, 100000, 250000);
            g_val = pick_value(262143, 10000, 50000);
            p_val = pick_value(32767, 1000, 5000);
            a_val = $urandom_range(0, 1);
          end
        endcase
        write_reg(ppm_pkg::REG_PULSE, p_val);
        write_reg(ppm_pkg::REG_GAP, g_val);
        write_reg(ppm_pkg::REG_ACTIVE, a_val);
        write_reg(ppm_pkg::REG_FRAME, f_val);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        frame_size = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
        for (int k = 0; k < frame_size; k++) begin
          if (phase == 3 && sent == 10) begin
            hold_token++;
          end
          if (phase == 4 && sent == 25) begin
            park_and_drain();
          end
          if ($urandom_range(0, 7) == 0) begin
            us = $urandom_range(0, 4095);
          end else begin
            us = $urandom_range(800, 2200);
          end
          offer_channel(us, k == frame_size - 1);
          sent++;
        end
      end
    end

    park_and_drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_syms.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
